FILE: rtl/core/xbs_pkg.sv
package xbs_pkg;

    localparam int BLOCK_BYTES = 128;
    localparam int ADDR_W      = $clog2(BLOCK_BYTES);
    localparam int CNT_W       = 8;
    localparam int LENGTH_BITS = 24;
    localparam int RETRY_W     = 4;
    localparam int KIND_W      = 3;
    localparam int PHASE_W     = 3;

    // Position of the checksum byte within a frame.
    localparam logic [CNT_W-1:0] FRAME_LAST = CNT_W'(BLOCK_BYTES + 3);

    localparam logic [KIND_W-1:0] KIND_FILE    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LINK    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_TIMEOUT = 3'd2;
    localparam logic [KIND_W-1:0] KIND_READY   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_START   = 3'd4;

    localparam logic [PHASE_W-1:0] PH_POLL  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_FILL  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_SEND  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_ACK   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_EOT   = 3'd4;
    localparam logic [PHASE_W-1:0] PH_DONE  = 3'd5;
    localparam logic [PHASE_W-1:0] PH_ABORT = 3'd6;

    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_NAK = 8'h15;

    localparam logic [RETRY_W-1:0] RETRY_RESET = 4'd10;

    localparam logic CFG_FILE_LENGTH = 1'b0;
    localparam logic CFG_RETRY_LIMIT = 1'b1;

    // One result as it leaves the control unit; the data byte may still come
    // from the buffer read, which is registered and completes in the next cycle.
    typedef struct packed {
        logic               tx_valid;
        logic               use_mem;
        logic [7:0]         tx_byte;
        logic               frame_end;
        logic [PHASE_W-1:0] phase;
        logic [7:0]         block_tag;
    } xbs_res_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } xbs_mem_req_t;

endpackage

FILE: rtl/core/xmodem_block_sender.sv
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  s_tdata: value; s_tuser: kind
// m_        out  m_tvalid/m_tready  m_tdata: tx_valid, tx_byte, phase, block_tag;
//                                   m_tlast: frame_end
// cfg_      in   cfg_wr_en          cfg_index, cfg_wdata
//
// Every request yields exactly one registered result; one is taken per cycle
// unless stalled. Control state sits in registers and the 128-byte block buffer
// in a synchronous RAM whose registered read data feeds the output stage directly.
// aresetn is synchronous and active low; it leaves the block in the done phase.
// s_tready follows the output register: a request is taken whenever the result
// register is empty or is being drained in the same cycle.
module xmodem_block_sender
    import xbs_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] value
    input  logic [KIND_W-1:0]      s_tuser,   // [2:0] kind
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [23:0]            m_tdata,   // [0] tx_valid, [8:1] tx_byte,
                                              // [11:9] phase, [19:12] block_tag
    output logic                   m_tlast,   // frame_end
    input  logic                   cfg_wr_en,
    input  logic                   cfg_index,
    input  logic [LENGTH_BITS-1:0] cfg_wdata
);

    logic [LENGTH_BITS-1:0] file_length_reg;
    logic [RETRY_W-1:0]     retry_limit_reg;
    logic                   take;
    logic                   m_valid_reg;
    xbs_res_t               res;
    xbs_res_t               out_reg;
    xbs_mem_req_t           mem_req;
    logic [7:0]             rd_data;
    logic [7:0]             tx_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            file_length_reg <= '0;
            retry_limit_reg <= RETRY_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_FILE_LENGTH: file_length_reg <= cfg_wdata;
                CFG_RETRY_LIMIT: retry_limit_reg <= cfg_wdata[RETRY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign s_tready = !m_valid_reg || m_tready;
    assign take     = s_tvalid && s_tready;

    xbs_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .take        (take),
        .kind        (s_tuser),
        .value       (s_tdata),
        .file_length (file_length_reg),
        .retry_limit (retry_limit_reg),
        .mem_req     (mem_req),
        .res         (res)
    );

    xbs_buffer u_buffer (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_tready) begin
            m_valid_reg <= take;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            out_reg <= res;
        end
    end

    // The buffer read lands in the same cycle as the result it belongs to and
    // holds while the result is stalled, since reads happen only on a take.
    assign tx_byte  = out_reg.use_mem ? rd_data : out_reg.tx_byte;
    assign m_tvalid = m_valid_reg;
    assign m_tlast  = out_reg.frame_end;
    assign m_tdata  = {4'd0, out_reg.block_tag, out_reg.phase, tx_byte, out_reg.tx_valid};

    a_take_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        take |=> m_valid_reg)
        else $error("accepted request produced no result");

    a_frame_end_sends: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && out_reg.frame_end |-> out_reg.tx_valid && !out_reg.use_mem)
        else $error("frame end without a transmitted constant byte");

    a_idle_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !out_reg.tx_valid |-> tx_byte == 8'd0)
        else $error("byte present on a result without transmission");

    a_mem_only_sending: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_req.rd_en |-> take && !mem_req.wr_en && res.phase == PH_SEND)
        else $error("buffer read outside frame transmission");

endmodule

FILE: rtl/core/xbs_buffer.sv
module xbs_buffer
    import xbs_pkg::*;
(
    input  logic         aclk,
    input  xbs_mem_req_t req,
    output logic [7:0]   rd_data
);

    logic [7:0] mem [BLOCK_BYTES];

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

FILE: rtl/core/xbs_ctrl.sv
module xbs_ctrl
    import xbs_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   take,
    input  logic [KIND_W-1:0]      kind,
    input  logic [7:0]             value,
    input  logic [LENGTH_BITS-1:0] file_length,
    input  logic [RETRY_W-1:0]     retry_limit,
    output xbs_mem_req_t           mem_req,
    output xbs_res_t               res
);

    logic [PHASE_W-1:0]     phase_reg, phase_next;
    logic [RETRY_W-1:0]     retries_reg, retries_next;
    logic [7:0]             block_reg, block_next;
    logic [7:0]             sum_reg, sum_next;
    logic [CNT_W-1:0]       fill_reg, fill_next;
    logic [CNT_W-1:0]       pos_reg, pos_next;
    logic [LENGTH_BITS-1:0] taken_reg, taken_next;

    always_comb begin
        logic [CNT_W-1:0] d;
        logic             is_fail;

        d            = pos_reg - CNT_W'(3);
        is_fail      = (kind inside {KIND_LINK, KIND_TIMEOUT});
        phase_next   = phase_reg;
        retries_next = retries_reg;
        block_next   = block_reg;
        sum_next     = sum_reg;
        fill_next    = fill_reg;
        pos_next     = pos_reg;
        taken_next   = taken_reg;
        mem_req      = '0;
        mem_req.wr_addr = fill_reg[ADDR_W-1:0];
        mem_req.wr_data = value;
        mem_req.rd_addr = d[ADDR_W-1:0];
        res          = '0;

        if (take) begin
            if (kind == KIND_START) begin
                block_next   = 8'd1;
                retries_next = retry_limit;
                taken_next   = '0;
                fill_next    = '0;
                sum_next     = '0;
                pos_next     = '0;
                phase_next   = PH_POLL;
            end else begin
                case (phase_reg)
                    PH_POLL: begin
                        if (kind == KIND_LINK && value == CH_NAK) begin
                            fill_next  = '0;
                            sum_next   = '0;
                            pos_next   = '0;
                            phase_next = (taken_reg < file_length) ? PH_FILL : PH_EOT;
                        end else if (is_fail) begin
                            if (retries_reg <= RETRY_W'(1)) begin
                                retries_next = '0;
                                phase_next   = PH_ABORT;
                            end else begin
                                retries_next = retries_reg - RETRY_W'(1);
                            end
                        end
                    end
                    PH_FILL: begin
                        if (kind == KIND_FILE) begin
                            if (fill_reg < CNT_W'(BLOCK_BYTES)) begin
                                mem_req.wr_en = 1'b1;
                                fill_next     = fill_reg + CNT_W'(1);
                            end
                            sum_next   = sum_reg + value;
                            taken_next = taken_reg + LENGTH_BITS'(1);
                            if (fill_next >= CNT_W'(BLOCK_BYTES) ||
                                taken_next >= file_length) begin
                                pos_next     = '0;
                                retries_next = retry_limit;
                                phase_next   = PH_SEND;
                            end
                        end
                    end
                    PH_SEND: begin
                        if (kind == KIND_READY) begin
                            res.tx_valid = 1'b1;
                            if (pos_reg == CNT_W'(0)) begin
                                res.tx_byte = CH_SOH;
                            end else if (pos_reg == CNT_W'(1)) begin
                                res.tx_byte = block_reg;
                            end else if (pos_reg == CNT_W'(2)) begin
                                res.tx_byte = ~block_reg;
                            end else if (pos_reg < FRAME_LAST) begin
                                // Bytes past the end of the file are sent as zero.
                                if (d < fill_reg) begin
                                    mem_req.rd_en = 1'b1;
                                    res.use_mem   = 1'b1;
                                end
                            end else begin
                                res.tx_byte   = sum_reg;
                                res.frame_end = 1'b1;
                            end
                            if (pos_reg >= FRAME_LAST) begin
                                pos_next   = '0;
                                phase_next = PH_ACK;
                            end else begin
                                pos_next = pos_reg + CNT_W'(1);
                            end
                        end
                    end
                    PH_ACK: begin
                        if (kind == KIND_LINK && value == CH_ACK) begin
                            block_next = (block_reg == 8'hFF) ? 8'd1 : block_reg + 8'd1;
                            fill_next  = '0;
                            sum_next   = '0;
                            pos_next   = '0;
                            phase_next = (taken_reg < file_length) ? PH_FILL : PH_EOT;
                        end else if (is_fail) begin
                            if (retries_reg <= RETRY_W'(1)) begin
                                retries_next = '0;
                                phase_next   = PH_ABORT;
                            end else begin
                                retries_next = retries_reg - RETRY_W'(1);
                                pos_next     = '0;
                                phase_next   = PH_SEND;
                            end
                        end
                    end
                    PH_EOT: begin
                        if (kind == KIND_READY) begin
                            res.tx_valid  = 1'b1;
                            res.tx_byte   = CH_EOT;
                            res.frame_end = 1'b1;
                            phase_next    = PH_DONE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        res.phase     = phase_next;
        res.block_tag = block_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_DONE;
            retries_reg <= '0;
            block_reg   <= 8'd1;
            sum_reg     <= '0;
            fill_reg    <= '0;
            pos_reg     <= '0;
            taken_reg   <= '0;
        end else begin
            phase_reg   <= phase_next;
            retries_reg <= retries_next;
            block_reg   <= block_next;
            sum_reg     <= sum_next;
            fill_reg    <= fill_next;
            pos_reg     <= pos_next;
            taken_reg   <= taken_next;
        end
    end

endmodule
